/* rtl/core/look_at_view_matrix_defines.svh */
// Assertion macros shared by the look-at view matrix RTL.
// Expects clk and rst in scope at the point of use.
`ifndef LOOK_AT_VIEW_MATRIX_DEFINES_SVH
`define LOOK_AT_VIEW_MATRIX_DEFINES_SVH

// check with reset masking
`define LAVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also covers reset cycles
`define LAVM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/lavm_pkg.sv */
// Shared types and fixed widths for the look-at view matrix pipeline.
// No dependencies.
package lavm_pkg;

  localparam int ROT_W   = 16;
  localparam int TRANS_W = 18;

  typedef struct packed {
    logic len_zero;
    logic yaw_zero;
    logic neg_s;
    logic neg_a;
    logic neg_b;
  } lavm_flags_t;

endpackage

/* rtl/core/lavm_pipe_ctl.sv */
// Valid/stall control for a chain of register stages with bubble collapse.
// Uses look_at_view_matrix_defines.svh for assertions.
`include "look_at_view_matrix_defines.svh"

module lavm_pipe_ctl #(
  parameter int STAGES = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              out_stall,
  output logic [STAGES-1:0] vld,
  output logic [STAGES-1:0] take
);

  always_comb begin
    take[STAGES-1] = !vld[STAGES-1] || !out_stall;
    for (int k = STAGES - 2; k >= 0; k--) begin
      take[k] = !vld[k] || take[k+1];
    end
  end

  assign in_stall = !take[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (take[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (take[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  `LAVM_ASSERT(a_stall_only_full, in_stall |-> (&vld), "input stalled with a bubble in the pipe")
  `LAVM_ASSERT(a_free_flow, !out_stall |-> !in_stall, "input stalled while output drains")
  `LAVM_ASSERT_RST(a_reset_empty, rst |=> (vld == '0), "pipe not empty after reset")

endmodule

/* rtl/core/lavm_sqrt.sv */
// Delta, squared length and two digit-by-digit floor square roots.
// Depends on lavm_pipe_ctl.
module lavm_sqrt #(
  parameter int CW = 15
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [CW-1:0] eye_x,
  input  logic signed [CW-1:0] eye_y,
  input  logic signed [CW-1:0] eye_z,
  input  logic signed [CW-1:0] target_x,
  input  logic signed [CW-1:0] target_y,
  input  logic signed [CW-1:0] target_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CW:0]          len,
  output logic [CW:0]          hor,
  output logic signed [CW:0]   dx,
  output logic signed [CW:0]   dy,
  output logic signed [CW:0]   dz,
  output logic signed [CW-1:0] ex,
  output logic signed [CW-1:0] ey,
  output logic signed [CW-1:0] ez
);

  localparam int DW     = CW + 1;
  localparam int PW     = 2 * DW;
  localparam int RW     = CW + 1;
  localparam int SQW    = 2 * CW + 1;
  localparam int NW     = 2 * RW;
  localparam int SIDE_W = 3 * DW + 3 * CW;
  localparam int STAGES = RW + 3;

  logic [STAGES-1:0] vld, take;

  logic signed [DW-1:0]   d0x, d0y, d0z;
  logic [3*CW-1:0]        e0;
  logic signed [PW-1:0]   mx, my, mz;
  logic [SQW-1:0]         q1x, q1y, q1z;
  logic [SIDE_W-1:0]      side1;

  logic [NW-1:0]     rad_l [RW+1];
  logic [NW-1:0]     rad_h [RW+1];
  logic [RW:0]       rem_l [RW+1];
  logic [RW:0]       rem_h [RW+1];
  logic [RW-1:0]     rt_l  [RW+1];
  logic [RW-1:0]     rt_h  [RW+1];
  logic [SIDE_W-1:0] side  [RW+1];

  lavm_pipe_ctl #(.STAGES(STAGES)) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .vld       (vld),
    .take      (take)
  );

  assign mx = PW'(d0x) * PW'(d0x);
  assign my = PW'(d0y) * PW'(d0y);
  assign mz = PW'(d0z) * PW'(d0z);

  always_ff @(posedge clk) begin
    if (take[0]) begin
      d0x <= DW'(target_x) - DW'(eye_x);
      d0y <= DW'(target_y) - DW'(eye_y);
      d0z <= DW'(target_z) - DW'(eye_z);
      e0  <= {eye_x, eye_y, eye_z};
    end
    if (take[1]) begin
      q1x   <= mx[SQW-1:0];
      q1y   <= my[SQW-1:0];
      q1z   <= mz[SQW-1:0];
      side1 <= {d0x, d0y, d0z, e0};
    end
    if (take[2]) begin
      rad_l[0] <= NW'(q1x) + NW'(q1y) + NW'(q1z);
      rad_h[0] <= NW'(q1x) + NW'(q1z);
      rem_l[0] <= '0;
      rem_h[0] <= '0;
      rt_l[0]  <= '0;
      rt_h[0]  <= '0;
      side[0]  <= side1;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_root
    logic [RW+2:0] sh_l, tr_l, df_l, sh_h, tr_h, df_h;

    assign sh_l = {rem_l[k], rad_l[k][NW-1 -: 2]};
    assign tr_l = {1'b0, rt_l[k], 2'b01};
    assign df_l = sh_l - tr_l;
    assign sh_h = {rem_h[k], rad_h[k][NW-1 -: 2]};
    assign tr_h = {1'b0, rt_h[k], 2'b01};
    assign df_h = sh_h - tr_h;

    always_ff @(posedge clk) begin
      if (take[k+3]) begin
        if (sh_l >= tr_l) begin
          rem_l[k+1] <= df_l[RW:0];
          rt_l[k+1]  <= {rt_l[k][RW-2:0], 1'b1};
        end else begin
          rem_l[k+1] <= sh_l[RW:0];
          rt_l[k+1]  <= {rt_l[k][RW-2:0], 1'b0};
        end
        if (sh_h >= tr_h) begin
          rem_h[k+1] <= df_h[RW:0];
          rt_h[k+1]  <= {rt_h[k][RW-2:0], 1'b1};
        end else begin
          rem_h[k+1] <= sh_h[RW:0];
          rt_h[k+1]  <= {rt_h[k][RW-2:0], 1'b0};
        end
        rad_l[k+1] <= rad_l[k] << 2;
        rad_h[k+1] <= rad_h[k] << 2;
        side[k+1]  <= side[k];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign len       = rt_l[RW];
  assign hor       = rt_h[RW];
  assign dx        = side[RW][SIDE_W-1 -: DW];
  assign dy        = side[RW][SIDE_W-DW-1 -: DW];
  assign dz        = side[RW][SIDE_W-2*DW-1 -: DW];
  assign ex        = side[RW][3*CW-1 -: CW];
  assign ey        = side[RW][2*CW-1 -: CW];
  assign ez        = side[RW][CW-1:0];

endmodule

/* rtl/core/lavm_div.sv */
// Four restoring fractional dividers, one quotient bit per stage.
// Depends on lavm_pkg and lavm_pipe_ctl.
module lavm_div #(
  parameter int CW = 15,
  parameter int FW = 12
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CW:0]            len,
  input  logic [CW:0]            hor,
  input  logic signed [CW:0]     dx,
  input  logic signed [CW:0]     dy,
  input  logic signed [CW:0]     dz,
  input  logic signed [CW-1:0]   ex,
  input  logic signed [CW-1:0]   ey,
  input  logic signed [CW-1:0]   ez,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FW:0]            qc,
  output logic [FW:0]            qs,
  output logic [FW:0]            qa,
  output logic [FW:0]            qb,
  output lavm_pkg::lavm_flags_t  flg,
  output logic signed [CW:0]     nex,
  output logic signed [CW:0]     ney,
  output logic signed [CW:0]     nez
);

  localparam int DW   = CW + 1;
  localparam int RW   = CW + 1;
  localparam int QW   = FW + 1;
  localparam int NSTG = FW + 2;

  logic [NSTG-1:0] vld, take;

  logic [RW-1:0]         rem [NSTG][4];
  logic [QW-1:0]         quo [NSTG][4];
  logic [RW-1:0]         dl  [NSTG];
  logic [RW-1:0]         dh  [NSTG];
  lavm_pkg::lavm_flags_t fl  [NSTG];
  logic [3*DW-1:0]       ne  [NSTG];
  logic [RW-1:0]         adx, ady, adz;

  lavm_pipe_ctl #(.STAGES(NSTG)) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .vld       (vld),
    .take      (take)
  );

  assign adx = dx[DW-1] ? unsigned'(-dx) : unsigned'(dx);
  assign ady = dy[DW-1] ? unsigned'(-dy) : unsigned'(dy);
  assign adz = dz[DW-1] ? unsigned'(-dz) : unsigned'(dz);

  always_ff @(posedge clk) begin
    if (take[0]) begin
      rem[0][0]      <= hor;
      rem[0][1]      <= ady;
      rem[0][2]      <= adz;
      rem[0][3]      <= adx;
      for (int l = 0; l < 4; l++) begin
        quo[0][l] <= '0;
      end
      dl[0]          <= len;
      dh[0]          <= hor;
      fl[0].len_zero <= (len == '0);
      fl[0].yaw_zero <= (hor == '0);
      fl[0].neg_s    <= dy[DW-1];
      fl[0].neg_a    <= dz[DW-1];
      fl[0].neg_b    <= dx[DW-1];
      ne[0]          <= {-DW'(ex), -DW'(ey), -DW'(ez)};
    end
  end

  for (genvar j = 0; j <= FW; j++) begin : g_step
    always_ff @(posedge clk) begin
      if (take[j+1]) begin
        dl[j+1] <= dl[j];
        dh[j+1] <= dh[j];
        fl[j+1] <= fl[j];
        ne[j+1] <= ne[j];
      end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [RW:0] rs, den, df;

      if (j == 0) begin : g_first
        assign rs = {1'b0, rem[j][l]};
      end else begin : g_next
        assign rs = {rem[j][l], 1'b0};
      end

      if (l < 2) begin : g_len
        assign den = {1'b0, dl[j]};
      end else begin : g_hor
        assign den = {1'b0, dh[j]};
      end

      assign df = rs - den;

      always_ff @(posedge clk) begin
        if (take[j+1]) begin
          if (rs >= den) begin
            rem[j+1][l] <= df[RW-1:0];
            quo[j+1][l] <= {quo[j][l][QW-2:0], 1'b1};
          end else begin
            rem[j+1][l] <= rs[RW-1:0];
            quo[j+1][l] <= {quo[j][l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = vld[NSTG-1];
  assign qc        = quo[NSTG-1][0];
  assign qs        = quo[NSTG-1][1];
  assign qa        = quo[NSTG-1][2];
  assign qb        = quo[NSTG-1][3];
  assign flg       = fl[NSTG-1];
  assign nex       = ne[NSTG-1][3*DW-1 -: DW];
  assign ney       = ne[NSTG-1][2*DW-1 -: DW];
  assign nez       = ne[NSTG-1][DW-1:0];

endmodule

/* rtl/core/lavm_rot.sv */
// Pitch-yaw product, special-case select and translation of the negated eye.
// Depends on lavm_pkg and lavm_pipe_ctl.
module lavm_rot #(
  parameter int CW = 15,
  parameter int FW = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [FW:0]                            qc,
  input  logic [FW:0]                            qs,
  input  logic [FW:0]                            qa,
  input  logic [FW:0]                            qb,
  input  lavm_pkg::lavm_flags_t                  flg,
  input  logic signed [CW:0]                     nex,
  input  logic signed [CW:0]                     ney,
  input  logic signed [CW:0]                     nez,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_00,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_01,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_02,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_10,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_11,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_12,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_20,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_21,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_22,
  output logic signed [lavm_pkg::TRANS_W-1:0]    trans_x,
  output logic signed [lavm_pkg::TRANS_W-1:0]    trans_y,
  output logic signed [lavm_pkg::TRANS_W-1:0]    trans_z
);

  localparam int DW  = CW + 1;
  localparam int EW  = lavm_pkg::ROT_W;
  localparam int OW  = lavm_pkg::TRANS_W;
  localparam int MW  = 2 * EW;
  localparam int TW  = EW + DW;
  localparam int SW  = (TW + 2 > OW + FW) ? TW + 2 : OW + FW;
  localparam logic signed [EW-1:0] ONE = EW'(2 ** FW);

  logic [4:0] vld, take;

  logic signed [EW-1:0]  sq, aq, bq;
  logic signed [EW-1:0]  c0, s0, ns0, a0, b0, nb0;
  logic signed [EW-1:0]  c1, s1, ns1, a1, nb1;
  lavm_pkg::lavm_flags_t fl0, fl1;
  logic signed [DW-1:0]  ne0 [3];
  logic signed [DW-1:0]  ne1 [3];
  logic signed [DW-1:0]  ne2 [3];
  logic signed [MW-1:0]  m10, m12, m20, m22;
  logic signed [MW-1:0]  p10, p12, p20, p22;
  logic signed [MW-1:0]  h10, h12, h20, h22;
  logic signed [EW-1:0]  r_next [9];
  logic signed [EW-1:0]  r2 [9];
  logic signed [EW-1:0]  r3 [9];
  logic signed [EW-1:0]  r4 [9];
  logic signed [TW-1:0]  tp [9];
  logic signed [TW-1:0]  t3 [9];
  logic signed [SW-1:0]  acc [3];
  logic signed [SW-1:0]  accs [3];
  logic signed [OW-1:0]  t4 [3];

  lavm_pipe_ctl #(.STAGES(5)) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .vld       (vld),
    .take      (take)
  );

  assign sq = flg.neg_s ? -signed'(EW'(qs)) : signed'(EW'(qs));
  assign aq = flg.neg_a ? -signed'(EW'(qa)) : signed'(EW'(qa));
  assign bq = flg.neg_b ? -signed'(EW'(qb)) : signed'(EW'(qb));

  assign m10 = MW'(ns0) * MW'(b0);
  assign m12 = MW'(ns0) * MW'(a0);
  assign m20 = MW'(c0) * MW'(b0);
  assign m22 = MW'(c0) * MW'(a0);

  assign h10 = p10 >>> FW;
  assign h12 = p12 >>> FW;
  assign h20 = p20 >>> FW;
  assign h22 = p22 >>> FW;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      r_next[i] = '0;
    end
    if (fl1.len_zero) begin
      r_next[0] = ONE;
      r_next[4] = ONE;
      r_next[8] = ONE;
    end else if (fl1.yaw_zero) begin
      r_next[0] = ONE;
      r_next[4] = c1;
      r_next[5] = ns1;
      r_next[7] = s1;
      r_next[8] = c1;
    end else begin
      r_next[0] = a1;
      r_next[2] = nb1;
      r_next[3] = h10[EW-1:0];
      r_next[4] = c1;
      r_next[5] = h12[EW-1:0];
      r_next[6] = h20[EW-1:0];
      r_next[7] = s1;
      r_next[8] = h22[EW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      tp[i] = TW'(r2[i]) * TW'(ne2[i % 3]);
    end
    for (int i = 0; i < 3; i++) begin
      acc[i]  = SW'(t3[3*i]) + SW'(t3[3*i+1]) + SW'(t3[3*i+2]);
      accs[i] = acc[i] >>> FW;
    end
  end

  always_ff @(posedge clk) begin
    if (take[0]) begin
      c0  <= signed'(EW'(qc));
      s0  <= sq;
      ns0 <= -sq;
      a0  <= aq;
      b0  <= bq;
      nb0 <= -bq;
      fl0 <= flg;
      ne0 <= '{nex, ney, nez};
    end
    if (take[1]) begin
      p10 <= m10;
      p12 <= m12;
      p20 <= m20;
      p22 <= m22;
      c1  <= c0;
      s1  <= s0;
      ns1 <= ns0;
      a1  <= a0;
      nb1 <= nb0;
      fl1 <= fl0;
      ne1 <= ne0;
    end
    if (take[2]) begin
      r2  <= r_next;
      ne2 <= ne1;
    end
    if (take[3]) begin
      t3 <= tp;
      r3 <= r2;
    end
    if (take[4]) begin
      r4 <= r3;
      for (int i = 0; i < 3; i++) begin
        t4[i] <= accs[i][OW-1:0];
      end
    end
  end

  assign out_valid = vld[4];
  assign rot_00    = r4[0];
  assign rot_01    = r4[1];
  assign rot_02    = r4[2];
  assign rot_10    = r4[3];
  assign rot_11    = r4[4];
  assign rot_12    = r4[5];
  assign rot_20    = r4[6];
  assign rot_21    = r4[7];
  assign rot_22    = r4[8];
  assign trans_x   = t4[0];
  assign trans_y   = t4[1];
  assign trans_z   = t4[2];

endmodule

/* rtl/core/look_at_view_matrix.sv */
// Look-at view matrix in signed fixed point: rotation and translation per eye/target word.
// Depends on lavm_pkg, lavm_sqrt, lavm_div and lavm_rot.
//
//   channel  handshake             payload
//   req      req_valid/req_stall   eye_x..eye_z, target_x..target_z
//   rsp      rsp_valid/rsp_stall   rot_00..rot_22, trans_x..trans_z
//
// One word per cycle while rsp_stall is low; each stage stalls only when it and all stages after it are full.
// Pipe depth is set by one root bit per stage in the square root
// and one quotient bit per stage in the divider.
// Reset (synchronous) empties the pipe; no clearing pass.
// A stalled result holds in the output register while bubbles upstream still fill.
module look_at_view_matrix #(
  parameter int COORD_BITS = 15,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic signed [COORD_BITS-1:0]           eye_x,
  input  logic signed [COORD_BITS-1:0]           eye_y,
  input  logic signed [COORD_BITS-1:0]           eye_z,
  input  logic signed [COORD_BITS-1:0]           target_x,
  input  logic signed [COORD_BITS-1:0]           target_y,
  input  logic signed [COORD_BITS-1:0]           target_z,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_00,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_01,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_02,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_10,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_11,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_12,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_20,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_21,
  output logic signed [lavm_pkg::ROT_W-1:0]      rot_22,
  output logic signed [lavm_pkg::TRANS_W-1:0]    trans_x,
  output logic signed [lavm_pkg::TRANS_W-1:0]    trans_y,
  output logic signed [lavm_pkg::TRANS_W-1:0]    trans_z
);

  logic                        sq_valid, sq_stall;
  logic [COORD_BITS:0]         len, hor;
  logic signed [COORD_BITS:0]  dx, dy, dz;
  logic signed [COORD_BITS-1:0] ex, ey, ez;

  logic                        dv_valid, dv_stall;
  logic [FRAC_BITS:0]          qc, qs, qa, qb;
  lavm_pkg::lavm_flags_t       flg;
  logic signed [COORD_BITS:0]  nex, ney, nez;

  lavm_sqrt #(.CW(COORD_BITS)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_stall  (req_stall),
    .eye_x     (eye_x),
    .eye_y     (eye_y),
    .eye_z     (eye_z),
    .target_x  (target_x),
    .target_y  (target_y),
    .target_z  (target_z),
    .out_valid (sq_valid),
    .out_stall (sq_stall),
    .len       (len),
    .hor       (hor),
    .dx        (dx),
    .dy        (dy),
    .dz        (dz),
    .ex        (ex),
    .ey        (ey),
    .ez        (ez)
  );

  lavm_div #(.CW(COORD_BITS), .FW(FRAC_BITS)) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sq_valid),
    .in_stall  (sq_stall),
    .len       (len),
    .hor       (hor),
    .dx        (dx),
    .dy        (dy),
    .dz        (dz),
    .ex        (ex),
    .ey        (ey),
    .ez        (ez),
    .out_valid (dv_valid),
    .out_stall (dv_stall),
    .qc        (qc),
    .qs        (qs),
    .qa        (qa),
    .qb        (qb),
    .flg       (flg),
    .nex       (nex),
    .ney       (ney),
    .nez       (nez)
  );

  lavm_rot #(.CW(COORD_BITS), .FW(FRAC_BITS)) u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dv_valid),
    .in_stall  (dv_stall),
    .qc        (qc),
    .qs        (qs),
    .qa        (qa),
    .qb        (qb),
    .flg       (flg),
    .nex       (nex),
    .ney       (ney),
    .nez       (nez),
    .out_valid (rsp_valid),
    .out_stall (rsp_stall),
    .rot_00    (rot_00),
    .rot_01    (rot_01),
    .rot_02    (rot_02),
    .rot_10    (rot_10),
    .rot_11    (rot_11),
    .rot_12    (rot_12),
    .rot_20    (rot_20),
    .rot_21    (rot_21),
    .rot_22    (rot_22),
    .trans_x   (trans_x),
    .trans_y   (trans_y),
    .trans_z   (trans_z)
  );

endmodule

/* dv/tb_look_at_view_matrix.sv */
// Testbench for look_at_view_matrix: directed table plus random camera pairs, every result
// checked against a local fixed-point view matrix predictor or, for typed rows, an identity view.
// Depends on lavm_pkg and the look_at_view_matrix RTL.
module tb_look_at_view_matrix;

  localparam int CW = 15;
  localparam int FB = 12;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int N_RANDOM = 535;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD = 400;

  typedef logic signed [CW-1:0] coord_t;
  typedef longint mat_t [3][3];

  typedef struct packed {
    logic [8:0][lavm_pkg::ROT_W-1:0]   rot;
    logic [2:0][lavm_pkg::TRANS_W-1:0] trans;
  } view_t;

  typedef struct {
    coord_t e[6];
    bit     typed;
    longint tx, ty, tz;
  } row_t;

  logic clk, rst;
  logic req_valid, req_stall, rsp_valid, rsp_stall;
  coord_t eye_x, eye_y, eye_z, target_x, target_y, target_z;
  logic signed [lavm_pkg::ROT_W-1:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
  logic signed [lavm_pkg::ROT_W-1:0] rot_20, rot_21, rot_22;
  logic signed [lavm_pkg::TRANS_W-1:0] trans_x, trans_y, trans_z;

  view_t view_q[$];
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  look_at_view_matrix dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint wrap16(longint x);
    logic signed [15:0] t;
    t = x[15:0];
    return longint'(t);
  endfunction

  function automatic longint isqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic mat_t set_ident();
    mat_t m;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? ONE : 0;
    return m;
  endfunction

  function automatic mat_t mat_mul_fx(mat_t a, mat_t b);
    mat_t r;
    longint acc;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
        r[i][j] = wrap16(acc >>> FB);
      end
    return r;
  endfunction

  function automatic view_t predict_view(coord_t c[6]);
    longint ev[3], d[3], sxz, len, lxz, acc;
    mat_t r, m;
    view_t v;
    for (int i = 0; i < 3; i++) begin
      ev[i] = longint'(c[i]);
      d[i] = longint'(c[i+3]) - ev[i];
    end
    sxz = d[0] * d[0] + d[2] * d[2];
    len = isqrt(sxz + d[1] * d[1]);
    lxz = isqrt(sxz);
    r = set_ident();
    if (len != 0) begin
      m = set_ident();
      m[2][2] = wrap16((lxz * ONE) / len);
      m[2][1] = wrap16((d[1] * ONE) / len);
      m[1][2] = wrap16(-m[2][1]);
      m[1][1] = m[2][2];
      r = mat_mul_fx(r, m);
      if (lxz != 0) begin
        m = set_ident();
        m[0][0] = wrap16((d[2] * ONE) / lxz);
        m[2][2] = m[0][0];
        m[2][0] = wrap16((d[0] * ONE) / lxz);
        m[0][2] = wrap16(-m[2][0]);
        r = mat_mul_fx(r, m);
      end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) v.rot[8 - (i*3 + j)] = r[i][j][15:0];
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += r[i][j] * (-ev[j]);
      acc = acc >>> FB;
      v.trans[2 - i] = acc[lavm_pkg::TRANS_W-1:0];
    end
    return v;
  endfunction

  function automatic view_t identity_view(longint tx, longint ty, longint tz);
    view_t v;
    for (int k = 0; k < 9; k++) v.rot[8 - k] = (k % 4 == 0) ? ONE[15:0] : 16'd0;
    v.trans[2] = tx[lavm_pkg::TRANS_W-1:0];
    v.trans[1] = ty[lavm_pkg::TRANS_W-1:0];
    v.trans[0] = tz[lavm_pkg::TRANS_W-1:0];
    return v;
  endfunction

  function automatic coord_t rnd_coord();
    return coord_t'($urandom);
  endfunction

  function automatic row_t make_row(longint a, b, c, d, e, f);
    row_t r;
    r.e[0] = coord_t'(a); r.e[1] = coord_t'(b); r.e[2] = coord_t'(c);
    r.e[3] = coord_t'(d); r.e[4] = coord_t'(e); r.e[5] = coord_t'(f);
    r.typed = 0;
    return r;
  endfunction

  function automatic row_t rnd_row();
    row_t r;
    int kind;
    int dlt;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 6; i++) r.e[i] = rnd_coord();
    r.typed = 0;
    case (kind)
      0: for (int i = 0; i < 3; i++) r.e[i+3] = r.e[i];
      1: begin
        r.e[3] = r.e[0];
        r.e[5] = r.e[2];
      end
      2, 3, 4: begin
        dlt = $urandom_range(1, 400);
        for (int i = 0; i < 3; i++) begin
          r.e[i] = coord_t'($signed($urandom_range(0, 32000)) - 16000);
          r.e[i+3] = coord_t'(r.e[i] + $signed($urandom_range(0, 2*dlt)) - dlt);
        end
      end
      5: for (int i = 0; i < 6; i++) r.e[i] = $urandom_range(0, 1) ? coord_t'(-16384)
                                                                   : coord_t'(16383);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(row_t r, int gap);
    view_t v;
    if (gap > 0) begin
      req_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    eye_x <= r.e[0]; eye_y <= r.e[1]; eye_z <= r.e[2];
    target_x <= r.e[3]; target_y <= r.e[4]; target_z <= r.e[5];
    req_valid <= 1;
    do @(posedge clk); while (req_stall);
    v = r.typed ? identity_view(r.tx, r.ty, r.tz) : predict_view(r.e);
    view_q.push_back(v);
  endtask

  task automatic drain_views();
    req_valid <= 0;
    while (view_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    row_t tbl[$];
    row_t r;
    int gap;
    rst = 1;
    req_valid = 0;
    rsp_stall = 0;
    eye_x = 0; eye_y = 0; eye_z = 0;
    target_x = 0; target_y = 0; target_z = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    r = make_row(0, 0, 0, 0, 0, 0);
    r.typed = 1; r.tx = 0; r.ty = 0; r.tz = 0;
    tbl.push_back(r);
    r = make_row(5, -7, 3, 5, -7, 3);
    r.typed = 1; r.tx = -5; r.ty = 7; r.tz = -3;
    tbl.push_back(r);
    r = make_row(-16384, -16384, -16384, -16384, -16384, -16384);
    r.typed = 1; r.tx = 16384; r.ty = 16384; r.tz = 16384;
    tbl.push_back(r);
    r = make_row(16383, 16383, 16383, 16383, 16383, 16383);
    r.typed = 1; r.tx = -16383; r.ty = -16383; r.tz = -16383;
    tbl.push_back(r);
    tbl.push_back(make_row(0, 0, 0, 0, 100, 0));
    tbl.push_back(make_row(0, 0, 0, 0, -100, 0));
    tbl.push_back(make_row(3, -16384, 9, 3, 16383, 9));
    tbl.push_back(make_row(0, 0, 0, 0, 0, 1));
    tbl.push_back(make_row(0, 0, 0, 1, 0, 0));
    tbl.push_back(make_row(0, 0, 0, -1, -1, -1));
    tbl.push_back(make_row(-16384, -16384, -16384, 16383, 16383, 16383));
    tbl.push_back(make_row(16383, 16383, 16383, -16384, -16384, -16384));
    tbl.push_back(make_row(16383, -16384, 16383, -16384, 16383, -16384));
    tbl.push_back(make_row(-16384, 0, 16383, 16383, 0, -16384));
    tbl.push_back(make_row(100, 200, 300, 101, 200, 300));
    tbl.push_back(make_row(-5000, 1234, 777, 4321, -999, -8000));

    foreach (tbl[i]) send_word(tbl[i], $urandom_range(0, 3));
    drain_views();

    for (int n = 0; n < N_RANDOM; n++) begin
      gap = (n >= 200 && n < 260) ? 0 : $urandom_range(0, 9);
      if (n == 350) drain_views();
      send_word(rnd_row(), gap);
    end
    req_valid <= 0;
    stim_done = 1;
  end

  initial begin
    view_t got, want;
    int n;
    bit held;
    held = 0;
    @(negedge rst);
    forever begin
      if (!held && results_seen == 100) begin
        held = 1;
        rsp_stall <= 1;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        n = (results_seen >= 150 && results_seen < 220) ? 0 : $urandom_range(0, 9);
        if (n > 0) begin
          rsp_stall <= 1;
          repeat (n) @(posedge clk);
        end
      end
      rsp_stall <= 0;
      do @(posedge clk); while (!rsp_valid);
      results_seen++;
      got.rot = {rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22};
      got.trans = {trans_x, trans_y, trans_z};
      if (view_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = view_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_look_at_view_matrix: done, errors");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (view_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatches == 0 && view_q.size() == 0) begin
      $display("tb_look_at_view_matrix: done, clean");
    end else begin
      $display("tb_look_at_view_matrix: done, errors");
    end
    $finish;
  end

endmodule

/* look_at_view_matrix.f */
+incdir+rtl/core
rtl/core/lavm_pkg.sv
rtl/core/lavm_pipe_ctl.sv
rtl/core/lavm_sqrt.sv
rtl/core/lavm_div.sv
rtl/core/lavm_rot.sv
rtl/core/look_at_view_matrix.sv
dv/tb_look_at_view_matrix.sv
